/* rtl/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform unit.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * Q_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W - FRAC_W;
    localparam int ROWS      = 4;
    localparam int COLS      = 3;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 4;

    typedef logic signed [Q_W-1:0]    q16_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [REG_W-1:0]         cfg_word_t;
    typedef cfg_word_t [NUM_REGS-1:0] cfg_bank_t;

    // register index codes
    localparam cfg_idx_t REG_R0_A = cfg_idx_t'(0);
    localparam cfg_idx_t REG_R0_B = cfg_idx_t'(1);
    localparam cfg_idx_t REG_R1_A = cfg_idx_t'(2);
    localparam cfg_idx_t REG_R1_B = cfg_idx_t'(3);
    localparam cfg_idx_t REG_R2_A = cfg_idx_t'(4);
    localparam cfg_idx_t REG_R2_B = cfg_idx_t'(5);
    localparam cfg_idx_t REG_R3_A = cfg_idx_t'(6);
    localparam cfg_idx_t REG_R3_B = cfg_idx_t'(7);

    // identity matrix, 1.0 on the diagonal
    localparam cfg_word_t ONE_LO  = cfg_word_t'(64'h0000_0000_0001_0000);
    localparam cfg_word_t ONE_HI  = cfg_word_t'(64'h0001_0000_0000_0000);
    localparam cfg_word_t ZERO_WD = cfg_word_t'(64'h0);
    localparam cfg_bank_t COEF_RESET = {ONE_HI, ZERO_WD, ONE_LO, ZERO_WD,
                                        ZERO_WD, ONE_HI, ZERO_WD, ONE_LO};

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam q16_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q16_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

/* rtl/hpt_cfg.sv */
// ----------------------------------------------------------------------------
// hpt_cfg
// Coefficient register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module hpt_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  hpt_pkg::cfg_idx_t  cfg_index,
    input  hpt_pkg::cfg_word_t cfg_data,
    output hpt_pkg::cfg_bank_t bank
);
    import hpt_pkg::*;

    cfg_bank_t bank_reg;

    assign cfg_ready = 1'b1;
    assign bank      = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_R0_A, REG_R0_B, REG_R1_A, REG_R1_B,
                REG_R2_A, REG_R2_B, REG_R3_A, REG_R3_B:
                begin
                    bank_reg[cfg_index[2:0]] <= cfg_data;
                end
                default:
                begin
                    // index beyond the bank is dropped
                end
            endcase
        end
    end

endmodule

/* rtl/hpt_lane.sv */
// ----------------------------------------------------------------------------
// hpt_lane
// One output column: three products, exact sum with translation, round and
// saturate to Q16.16.
// ----------------------------------------------------------------------------
module hpt_lane
(
    input  logic                clk,
    input  hpt_pkg::pipe_ctrl_t ctrl,
    input  hpt_pkg::q16_t       in_x,
    input  hpt_pkg::q16_t       in_y,
    input  hpt_pkg::q16_t       in_z,
    input  logic                is_point,
    input  hpt_pkg::q16_t       coef [hpt_pkg::ROWS],
    output hpt_pkg::q16_t       res,
    output logic                sat
);
    import hpt_pkg::*;

    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    q16_t                     p3_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [RND_W-1:0]  rnd;
    q16_t                     res_reg, res_next;
    logic                     sat_reg, sat_next;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            p0_reg <= in_x * coef[0];
            p1_reg <= in_y * coef[1];
            p2_reg <= in_z * coef[2];
            p3_reg <= is_point ? coef[3] : '0;
        end
    end

    // stage 2: exact Q32.32 sum plus the rounding half, w term is coefficient times 1.0
    always_comb
    begin
        sum_next = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg)
                 + (SUM_W'(p3_reg) <<< FRAC_W) + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            sum_reg <= sum_next;
        end
    end

    // stage 3: floor shift, then clamp when the upper bits are not all sign
    always_comb
    begin
        rnd      = sum_reg[SUM_W-1:FRAC_W];
        sat_next = !((&rnd[RND_W-1:Q_W-1]) || !(|rnd[RND_W-1:Q_W-1]));
        if (sat_next)
        begin
            res_next = rnd[RND_W-1] ? Q_MIN : Q_MAX;
        end
        else
        begin
            res_next = rnd[Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

/* rtl/hpt_merge.sv */
// ----------------------------------------------------------------------------
// hpt_merge
// Joins the lane results into one transaction and holds the output register.
// ----------------------------------------------------------------------------
module hpt_merge
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  hpt_pkg::q16_t lane_res [hpt_pkg::COLS],
    input  logic          lane_sat [hpt_pkg::COLS],
    output logic          adv,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // out_x, out_y, out_z
    output logic [0:0]    m_tuser    // overflow
);
    import hpt_pkg::*;

    logic        vo_reg;
    logic [95:0] data_reg;
    logic        ovf_reg;

    assign adv = !vo_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= {lane_res[2], lane_res[1], lane_res[0]};
            ovf_reg  <= lane_sat[0] || lane_sat[1] || lane_sat[2];
        end
    end

    assign m_tvalid   = vo_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = ovf_reg;

endmodule

/* rtl/homogeneous_point_transform_unit.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// Transforms Q16.16 points or directions by a 4x4 row-major matrix, three
// column lanes side by side, rounded and saturated.
// ----------------------------------------------------------------------------
//  channel  dir  signals                              content
//  s_*      in   s_tvalid s_tready s_tdata s_tuser    x, y, z ; is_point
//  m_*      out  m_tvalid m_tready m_tdata m_tuser    x, y, z ; overflow
//  cfg_*    in   cfg_valid cfg_ready cfg_index cfg_data  coefficient writes
//
//  one transaction per cycle sustained while m_tready is high; registered
//  stages multiply, sum, round/saturate, output register; the 32x32 multipliers set the stage.
//  reset loads the identity matrix and empties the pipeline.
//  empty stages collapse, so s_tready drops only with all four stages full
//  and m_tready low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,   // in_x, in_y, in_z
    input  logic [0:0]          s_tuser,   // is_point
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata,   // out_x, out_y, out_z
    output logic [0:0]          m_tuser,   // overflow
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  hpt_pkg::cfg_idx_t   cfg_index,
    input  hpt_pkg::cfg_word_t  cfg_data
);
    import hpt_pkg::*;

    cfg_bank_t  bank;
    q16_t       lane_coef [COLS][ROWS];
    q16_t       lane_res  [COLS];
    logic       lane_sat  [COLS];
    pipe_ctrl_t ctrl;
    logic       v1_reg, v2_reg, v3_reg;
    logic       adv1, adv2, adv3, adv_o;
    logic       s_fire;

    hpt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bank      (bank)
    );

    // stage advance, each stage moves when empty or when the next one moves
    assign adv3     = !v3_reg || adv_o;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign s_fire   = s_tvalid && s_tready;
    assign ctrl     = '{en1: adv1, en2: adv2, en3: adv3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_fire;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    for (genvar c = 0; c < COLS; c++)
    begin : g_lane
        for (genvar r = 0; r < ROWS; r++)
        begin : g_coef
            // m[r][c] sits in register 2r + c/2, half c%2
            assign lane_coef[c][r] = $signed(bank[r*2 + c/2][(c%2)*Q_W +: Q_W]);
        end

        hpt_lane u_lane
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .in_x     ($signed(s_tdata[31:0])),
            .in_y     ($signed(s_tdata[63:32])),
            .in_z     ($signed(s_tdata[95:64])),
            .is_point (s_tuser[0]),
            .coef     (lane_coef[c]),
            .res      (lane_res[c]),
            .sat      (lane_sat[c])
        );
    end

    hpt_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .adv      (adv_o),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("front stage empty but input not ready");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> v1_reg)
        else $error("accepted transaction lost in first stage");

    a_stall_holds_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv_o) |=> (v3_reg && $stable(lane_res[0]) && $stable(lane_sat[0])))
        else $error("lane result changed while stalled");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && lane_sat[1]) |-> (lane_res[1] == Q_MAX || lane_res[1] == Q_MIN))
        else $error("saturated lane result not at a limit");

endmodule

/* tb/sv/tb_homogeneous_point_transform_unit.sv */
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform_unit
// Streams Q16.16 points and directions through the transform unit under
// random sender bursts and receiver stalls. Each accepted transaction is
// predicted from a local copy of the coefficient bank. Each result is
// compared field by field in order. The coefficient bank is reloaded
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_homogeneous_point_transform_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import hpt_pkg::*;

    localparam int   PIPE_LATENCY = 4;
    localparam q16_t ONE_Q        = 32'sh0001_0000;

    localparam cfg_bank_t COEF_IDENTITY = {64'h0001_0000_0000_0000, 64'h0,
                                           64'h0000_0000_0001_0000, 64'h0,
                                           64'h0, 64'h0001_0000_0000_0000,
                                           64'h0, 64'h0000_0000_0001_0000};

    typedef struct packed {
        logic is_point;
        q16_t z;
        q16_t y;
        q16_t x;
    } point_t;

    typedef struct packed {
        logic ovf;
        q16_t z;
        q16_t y;
        q16_t x;
    } xform_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // in_x, in_y, in_z
    logic [0:0]  s_tuser;   // is_point
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // out_x, out_y, out_z
    logic [0:0]  m_tuser;   // overflow
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    cfg_word_t   cfg_data;

    homogeneous_point_transform_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    point_t    pending_points[$];
    xform_t    expected_results[$];
    cfg_bank_t coef_model = COEF_IDENTITY;
    int        n_queued   = 0;
    int        n_accepted = 0;
    int        mismatches = 0;
    logic      in_fire    = 1'b0;
    logic      cfg_fire   = 1'b0;

    // exact Q32.32 sum of four products, round half up, saturate to Q16.16
    function automatic xform_t transform_point(cfg_bank_t bank, logic [95:0] data,
                                               logic is_point);
        q16_t                    vec [ROWS];
        q16_t                    coef;
        longint                  prod;
        logic signed [SUM_W-1:0] acc;
        logic signed [RND_W-1:0] rnd;
        q16_t                    lane [COLS];
        xform_t                  res;
        vec[0] = data[31:0];
        vec[1] = data[63:32];
        vec[2] = data[95:64];
        vec[3] = is_point ? ONE_Q : '0;
        res.ovf = 1'b0;
        for (int c = 0; c < COLS; c++)
        begin
            acc = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                coef = bank[2 * r + c / 2][32 * (c % 2) +: 32];
                prod = longint'(vec[r]) * longint'(coef);
                acc  = acc + prod;
            end
            acc = acc + 32768;
            rnd = acc >>> FRAC_W;
            if (rnd > Q_MAX)
            begin
                lane[c] = Q_MAX;
                res.ovf = 1'b1;
            end
            else if (rnd < Q_MIN)
            begin
                lane[c] = Q_MIN;
                res.ovf = 1'b1;
            end
            else
            begin
                lane[c] = q16_t'(rnd);
            end
        end
        res.x = lane[0];
        res.y = lane[1];
        res.z = lane[2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int     burst_left = 1;
    int     gap_left   = 0;
    point_t nxt;

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (pending_points.size() != 0 && gap_left == 0)
            begin
                nxt = pending_points.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.z, nxt.y, nxt.x};
                s_tuser  <= nxt.is_point;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: four stall modes, each kept for a randomly drawn span of cycles
    // ------------------------------------------------------------------------
    int       stall_mode = 0;
    int       stall_left = 0;
    logic [7:0] stall_pat = 8'hA5;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
            stall_pat  <= 8'($urandom_range(1, 255));
        end
        else
        begin
            stall_left <= stall_left - 1;
            stall_pat  <= {stall_pat[0], stall_pat[7:1]};
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= stall_pat[0];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on input transactions, checks output transactions
    // ------------------------------------------------------------------------
    xform_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire  <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
                coef_model[cfg_index[2:0]] <= cfg_data;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(transform_point(coef_model, s_tdata, s_tuser[0]));
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d",
                               $signed(want.x), $signed(m_tdata[31:0]));
                        mismatches++;
                    end
                    if (m_tdata[63:32] !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d",
                               $signed(want.y), $signed(m_tdata[63:32]));
                        mismatches++;
                    end
                    if (m_tdata[95:64] !== want.z)
                    begin
                        $error("out_z: expected %0d, got %0d",
                               $signed(want.z), $signed(m_tdata[95:64]));
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, m_tuser[0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_point(q16_t x, q16_t y, q16_t z, logic is_point);
        point_t pt;
        pt.x        = x;
        pt.y        = y;
        pt.z        = z;
        pt.is_point = is_point;
        pending_points.push_back(pt);
        n_queued++;
    endtask

    task automatic write_coef(cfg_idx_t idx, cfg_word_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(cfg_bank_t bank);
        for (int r = 0; r < NUM_REGS; r++)
            write_coef(cfg_idx_t'(r), bank[r]);
    endtask

    // sender holds off until every result is back and the pipeline is empty
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    function automatic q16_t pick_extreme();
        case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return ONE_Q;
            default: return -ONE_Q;
        endcase
    endfunction

    // kind 0 full range, kind 1 within +-4.0, otherwise an extreme value
    function automatic q16_t pick_coef(int kind);
        case (kind)
            0:       return q16_t'($urandom);
            1:       return q16_t'($urandom_range(0, 1 << 19) - (1 << 18));
            default: return pick_extreme();
        endcase
    endfunction

    function automatic q16_t pick_coord();
        case ($urandom_range(0, 3))
            0, 1:    return q16_t'($urandom);
            2:       return q16_t'($urandom_range(0, 1 << 21) - (1 << 20));
            default: return pick_extreme();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    cfg_bank_t bank;
    int        kind;

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity after reset: output equals input, directions untranslated
        add_point(Q_MAX, Q_MIN, '0, 1'b1);
        add_point(Q_MIN, Q_MAX, -32'sd1, 1'b0);
        add_point(32'sd1, -32'sd1, ONE_Q, 1'b1);
        add_point('0, '0, '0, 1'b0);
        wait_drained();

        // halves on the diagonal give exact rounding ties; the fourth column
        // holds junk that must not show
        bank               = '0;
        bank[REG_R0_A]     = {32'h0000_0000, 32'h0000_8000};
        bank[REG_R0_B]     = {32'h7FFF_FFFF, 32'h0000_0000};
        bank[REG_R1_A]     = {32'hFFFF_8000, 32'h0000_0000};
        bank[REG_R1_B]     = {32'h8000_0000, 32'h0000_0000};
        bank[REG_R2_B]     = {32'h1234_5678, 32'h0000_8000};
        bank[REG_R3_A]     = {32'h0000_0001, 32'h0000_8000};
        bank[REG_R3_B]     = {32'hFFFF_FFFF, 32'hFFFF_0000};
        load_matrix(bank);
        // writes past the last register are dropped
        write_coef(cfg_idx_t'(NUM_REGS), '1);
        write_coef(cfg_idx_t'(2 * NUM_REGS - 1), {$urandom, $urandom});
        add_point(32'sd1, 32'sd1, 32'sd1, 1'b0);
        add_point(-32'sd1, -32'sd1, -32'sd1, 1'b0);
        add_point(32'sd3, 32'sd3, 32'sd3, 1'b1);
        add_point(Q_MAX, Q_MIN, Q_MAX, 1'b1);
        wait_drained();

        // full-scale coefficients: saturation in both directions
        bank               = '0;
        bank[REG_R0_A]     = {32'h0000_0000, Q_MAX};
        bank[REG_R0_B]     = {ONE_Q, 32'h0000_0000};
        bank[REG_R1_A]     = {Q_MIN, 32'h0000_0000};
        bank[REG_R2_B]     = {32'h0000_0000, Q_MAX};
        bank[REG_R3_A]     = {Q_MIN, Q_MAX};
        load_matrix(bank);
        add_point(Q_MAX, Q_MAX, Q_MAX, 1'b1);
        add_point(Q_MIN, Q_MIN, Q_MIN, 1'b1);
        add_point('0, '0, '0, 1'b1);
        add_point('0, '0, '0, 1'b0);
        add_point(32'sd1, '0, '0, 1'b0);
        wait_drained();

        // random matrices, each phase split by a full drain
        for (int p = 0; p < 10; p++)
        begin
            kind = p % 5;
            if (kind == 4)
            begin
                bank = p[0] ? '1 : '0;
            end
            else if (kind == 2)
            begin
                bank           = COEF_IDENTITY;
                bank[REG_R3_A] = {pick_coef(1), pick_coef(0)};
                bank[REG_R3_B] = {pick_coef(0), pick_coef(1)};
            end
            else
            begin
                for (int r = 0; r < NUM_REGS; r++)
                    bank[r] = {pick_coef(kind), pick_coef(kind)};
            end
            load_matrix(bank);
            if ($urandom_range(0, 1) == 1)
                write_coef(cfg_idx_t'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
                           {$urandom, $urandom});
            for (int half = 0; half < 2; half++)
            begin
                for (int i = 0; i < 20; i++)
                    add_point(pick_coord(), pick_coord(), pick_coord(),
                              1'($urandom_range(0, 1)));
                wait_drained();
            end
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
